// File: hdl/wsd_pkg.sv
package wsd_pkg;

	// 7-bit length codes that select an extended length field
	localparam logic [6:0] L7_EXT16 = 7'd126;
	localparam logic [6:0] L7_EXT64 = 7'd127;

	// highest opcode taken (binary); anything above is a protocol error
	localparam logic [3:0] OPC_LAST_OK = 4'd2;

	// one result transfer
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_end;
		logic       frame_fin;
		logic [3:0] frame_opcode;
		logic       proto_error;
	} res_t;

endpackage

// File: hdl/wsd_parse.sv
module wsd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    in_byte,
	output logic          has_res,
	output wsd_pkg::res_t res
);

	localparam logic [1:0] PH_HDR  = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_ERR  = 2'd2;

	logic [1:0]  phase_q;
	logic [3:0]  cnt_q;
	logic        fin_q;
	logic [3:0]  opc_q;
	logic        msk_q;
	logic [6:0]  l7_q;
	logic [63:0] len_q;
	logic [31:0] key_q;
	logic [1:0]  kidx_q;

	logic [1:0]  phase_d;
	logic [3:0]  cnt_d;
	logic        fin_d;
	logic [3:0]  opc_d;
	logic        msk_d;
	logic [6:0]  l7_d;
	logic [63:0] len_d;
	logic [31:0] key_d;
	logic [1:0]  kidx_d;

	logic [3:0]  ext_n;
	logic [3:0]  need_n;
	logic [3:0]  cnt_inc;
	logic [3:0]  key_off;
	logic [6:0]  l7_eff;
	logic        msk_eff;
	logic [63:0] len_hdr;
	logic        hdr_done;

	// header length from the 7-bit code seen so far (or the one arriving now)
	always_comb begin
		l7_eff  = (cnt_q == 4'd1) ? in_byte[6:0] : l7_q;
		msk_eff = (cnt_q == 4'd1) ? in_byte[7] : msk_q;
		if (l7_eff == wsd_pkg::L7_EXT16) begin
			ext_n = 4'd2;
		end else if (l7_eff == wsd_pkg::L7_EXT64) begin
			ext_n = 4'd8;
		end else begin
			ext_n = 4'd0;
		end
		need_n  = 4'd2 + ext_n + (msk_eff ? 4'd4 : 4'd0);
		cnt_inc = cnt_q + 4'd1;
		key_off = cnt_q - 4'd2 - ext_n;
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		fin_d    = fin_q;
		opc_d    = opc_q;
		msk_d    = msk_q;
		l7_d     = l7_q;
		len_d    = len_q;
		key_d    = key_q;
		kidx_d   = kidx_q;
		len_hdr  = '0;
		hdr_done = 1'b0;
		res      = '0;
		res.frame_fin    = fin_q;
		res.frame_opcode = opc_q;
		unique case (phase_q)
			PH_HDR: begin
				cnt_d = cnt_inc;
				if (cnt_q == 4'd0) begin
					fin_d = in_byte[7];
					opc_d = in_byte[3:0];
				end else if (cnt_q == 4'd1) begin
					msk_d = in_byte[7];
					l7_d  = in_byte[6:0];
					len_d = '0;
					key_d = '0;
				end else if (cnt_q < 4'd2 + ext_n) begin
					len_d = {len_q[55:0], in_byte};
				end else begin
					key_d[8*key_off[1:0] +: 8] = in_byte;
				end
				hdr_done = (cnt_q != 4'd0) && (cnt_inc == need_n);
				len_hdr  = (ext_n == 4'd0) ? {57'd0, l7_eff} : len_d;
				if (hdr_done) begin
					cnt_d  = '0;
					kidx_d = '0;
					len_d  = len_hdr;
					if (opc_q > wsd_pkg::OPC_LAST_OK) begin
						phase_d = PH_ERR;
					end else if (len_hdr == '0) begin
						phase_d = PH_HDR;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				// len_q counts the payload bytes still to come
				res.payload_byte = in_byte ^ key_q[8*kidx_q +: 8];
				res.frame_end    = (len_q == 64'd1);
				len_d  = len_q - 64'd1;
				kidx_d = kidx_q + 2'd1;
				if (len_q == 64'd1) begin
					phase_d = PH_HDR;
				end
			end
			default: begin
				res.proto_error = 1'b1;
			end
		endcase
	end

	assign has_res = (phase_q != PH_HDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			opc_q   <= '0;
			msk_q   <= 1'b0;
			l7_q    <= '0;
			len_q   <= '0;
			key_q   <= '0;
			kidx_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			opc_q   <= opc_d;
			msk_q   <= msk_d;
			l7_q    <= l7_d;
			len_q   <= len_d;
			key_q   <= key_d;
			kidx_q  <= kidx_d;
		end
	end

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> len_q != 64'd0)
		else $error("payload phase with nothing left to send");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERR |=> phase_q == PH_ERR)
		else $error("error state left without reset");

	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 4'd14 && (phase_q == PH_HDR || cnt_q == 4'd0))
		else $error("header byte count out of range");

endmodule

// File: hdl/wsd_oreg.sv
module wsd_oreg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wsd_pkg::res_t din,
	input  logic          res_stall,
	output logic          res_valid,
	output logic          free,
	output wsd_pkg::res_t dout
);

	logic          vld_q;
	wsd_pkg::res_t data_q;

	// room for a new result when empty or when the held one leaves this cycle
	assign free      = !vld_q || !res_stall;
	assign res_valid = vld_q;
	assign dout      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!res_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// File: hdl/websocket_frame_deframer_top.sv
// A payload byte is held in the input stage, then in the result register, until its
// result transfer. Throughput: one byte per cycle, header bytes included, while no
// stalled result blocks the input; header bytes give no result.
// Reset (arst_n low, asynchronous): waits for a new frame header, error cleared,
// both registers empty.
module websocket_frame_deframer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] payload_byte,
	output logic       frame_end,
	output logic       frame_fin,
	output logic [3:0] frame_opcode,
	output logic       proto_error
);

	// Input stage: one byte held for the parser
	logic       v_s1;
	logic [7:0] byte_s1;

	// Parser handshake
	logic          has_res;
	logic          oreg_free;
	logic          adv;
	logic          accept;
	wsd_pkg::res_t res_nx;
	wsd_pkg::res_t res_out;

	// The held byte moves on when it yields no result (header byte) or the
	// result register has room. Frame state only updates when it moves on.
	assign adv       = v_s1 && (!has_res || oreg_free);
	assign src_stall = v_s1 && !adv;
	assign accept    = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	// Header collection, unmasking and frame/error tracking
	wsd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.in_byte (byte_s1),
		.has_res (has_res),
		.res     (res_nx)
	);

	// Result register; accepting a byte never waits on an empty slot here
	wsd_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && has_res),
		.din       (res_nx),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.free      (oreg_free),
		.dout      (res_out)
	);

	assign payload_byte = res_out.payload_byte;
	assign frame_end    = res_out.frame_end;
	assign frame_fin    = res_out.frame_fin;
	assign frame_opcode = res_out.frame_opcode;
	assign proto_error  = res_out.proto_error;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> v_s1 && res_valid && res_stall)
		else $error("input stalled with no stalled result ahead");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && proto_error |-> payload_byte == 8'd0 && !frame_end)
		else $error("error transfer carries payload");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// longest header: two fixed bytes, 64-bit length, masking key
	localparam int unsigned HDR_MAX = 14;
	localparam int unsigned ITEMS = 1950;
	// bytes kept back for the closing directed frame and the error tail
	localparam int unsigned TAIL_BYTES = 450;
	// receiver hold-off, long enough to back the block up into its input
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AFTER = 150;
	// about 2000 bytes with worst-case idle gaps between them, plus one
	// long hold-off; this is far above that
	localparam longint unsigned LIMIT = 2_000_000;

	localparam logic [3:0] OPC_CONT = 4'd0;
	localparam logic [3:0] OPC_TEXT = 4'd1;
	localparam logic [3:0] OPC_BIN = 4'd2;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

	// Expected-result store plus a bit-level predictor of the deframer.
	class unmask_board;
		typedef enum logic [1:0] {AWAIT_HDR, IN_BODY, STUCK_ERR} phase_e;

		phase_e        phase;
		logic [7:0]    hdr [HDR_MAX];
		int unsigned   hdr_cnt;
		logic          fin;
		logic [3:0]    opc;
		logic [31:0]   key;
		logic [63:0]   body_len;
		logic [63:0]   body_pos;
		wsd_pkg::res_t pending [$];
		int unsigned   fails;

		function new();
			phase = AWAIT_HDR;
			hdr_cnt = 0;
			fin = 1'b0;
			opc = '0;
			key = '0;
			body_len = '0;
			body_pos = '0;
			fails = 0;
		endfunction

		task report_mismatch(input string what);
			fails++;
			$display("%0t ns: mismatch: %s", $time, what);
		endtask

		// one accepted stream byte
		function void take_byte(input logic [7:0] b);
			logic [6:0] l7;
			int unsigned need;
			int unsigned pos;
			wsd_pkg::res_t r;
			case (phase)
				AWAIT_HDR: begin
					if (hdr_cnt < HDR_MAX) begin
						hdr[hdr_cnt] = b;
						hdr_cnt++;
					end
					if (hdr_cnt < 2)
						return;
					l7 = hdr[1][6:0];
					need = 2 + (l7 == wsd_pkg::L7_EXT16 ? 2 :
						(l7 == wsd_pkg::L7_EXT64 ? 8 : 0)) + (hdr[1][7] ? 4 : 0);
					if (hdr_cnt < need)
						return;
					fin = hdr[0][7];
					opc = hdr[0][3:0];
					if (l7 == wsd_pkg::L7_EXT16) begin
						body_len = {48'd0, hdr[2], hdr[3]};
						pos = 4;
					end else if (l7 == wsd_pkg::L7_EXT64) begin
						body_len = {hdr[2], hdr[3], hdr[4], hdr[5],
							hdr[6], hdr[7], hdr[8], hdr[9]};
						pos = 10;
					end else begin
						body_len = 64'(l7);
						pos = 2;
					end
					// key byte 0 is the first key byte on the wire
					key = hdr[1][7] ? {hdr[pos+3], hdr[pos+2], hdr[pos+1], hdr[pos]} : '0;
					body_pos = '0;
					hdr_cnt = 0;
					if (opc > wsd_pkg::OPC_LAST_OK)
						phase = STUCK_ERR;
					else if (body_len == 0)
						phase = AWAIT_HDR;
					else
						phase = IN_BODY;
				end
				IN_BODY: begin
					r.payload_byte = b ^ key[8*body_pos[1:0] +: 8];
					r.frame_end = (body_pos + 1 == body_len);
					r.frame_fin = fin;
					r.frame_opcode = opc;
					r.proto_error = 1'b0;
					pending.push_back(r);
					body_pos++;
					if (r.frame_end)
						phase = AWAIT_HDR;
				end
				default: begin
					r.payload_byte = '0;
					r.frame_end = 1'b0;
					r.frame_fin = fin;
					r.frame_opcode = opc;
					r.proto_error = 1'b1;
					pending.push_back(r);
				end
			endcase
		endfunction

		task match_byte(input wsd_pkg::res_t got);
			wsd_pkg::res_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result, byte %02h err %b",
					got.payload_byte, got.proto_error));
				return;
			end
			want = pending.pop_front();
			if (got.payload_byte !== want.payload_byte)
				report_mismatch($sformatf("payload_byte %02h, want %02h",
					got.payload_byte, want.payload_byte));
			if (got.frame_end !== want.frame_end)
				report_mismatch($sformatf("frame_end %b, want %b",
					got.frame_end, want.frame_end));
			if (got.frame_fin !== want.frame_fin)
				report_mismatch($sformatf("frame_fin %b, want %b",
					got.frame_fin, want.frame_fin));
			if (got.frame_opcode !== want.frame_opcode)
				report_mismatch($sformatf("frame_opcode %0d, want %0d",
					got.frame_opcode, want.frame_opcode));
			if (got.proto_error !== want.proto_error)
				report_mismatch($sformatf("proto_error %b, want %b",
					got.proto_error, want.proto_error));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	logic [7:0] in_byte;
	logic       res_valid;
	logic       res_stall;
	logic [7:0] payload_byte;
	logic       frame_end;
	logic       frame_fin;
	logic [3:0] frame_opcode;
	logic       proto_error;

	unmask_board book;

	// run statistics
	longint unsigned cycles = 0;
	int unsigned bytes_in = 0;
	int unsigned bytes_out = 0;
	int unsigned err_out = 0;
	int unsigned n_frames = 0;
	int unsigned n_masked = 0;
	int unsigned n_empty = 0;
	int unsigned n_ext16 = 0;
	int unsigned n_ext64 = 0;
	int unsigned src_calm = 0;

	websocket_frame_deframer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.in_byte      (in_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.payload_byte (payload_byte),
		.frame_end    (frame_end),
		.frame_fin    (frame_fin),
		.frame_opcode (frame_opcode),
		.proto_error  (proto_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length shared by both sides: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one byte and return right after the edge that takes it.
	// Inputs only move at the falling edge; each falling edge sees one update.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		if (src_calm > 0) begin
			src_calm--;
			gap = 0;
		end else begin
			gap = idle_len();
			// occasional back-to-back streak
			if ($urandom_range(0, 24) == 0)
				src_calm = $urandom_range(20, 80);
		end
		repeat (gap) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!(src_valid && !src_stall));
	endtask

	// One frame on the wire. body is the number of bytes sent after the header:
	// the payload length for good frames, anything for the error tail.
	// fill_ext alternates 00/ff payload bytes instead of random ones.
	task automatic send_frame(input logic [3:0] opc, input logic fin, input logic masked,
			input len_form_e form, input logic [63:0] len, input int unsigned body,
			input logic fill_ext, input logic [31:0] key);
		logic [6:0] l7;
		case (form)
			LEN_SHORT: l7 = len[6:0];
			LEN_EXT16: l7 = wsd_pkg::L7_EXT16;
			default:   l7 = wsd_pkg::L7_EXT64;
		endcase
		n_frames++;
		if (masked)
			n_masked++;
		if (len == 0)
			n_empty++;
		if (form == LEN_EXT16)
			n_ext16++;
		if (form == LEN_EXT64)
			n_ext64++;
		// reserved bits random: the block must ignore them
		push_byte({fin, 3'($urandom), opc});
		push_byte({masked, l7});
		if (form == LEN_EXT16) begin
			push_byte(len[15:8]);
			push_byte(len[7:0]);
		end else if (form == LEN_EXT64) begin
			for (int k = 7; k >= 0; k--)
				push_byte(len[8*k +: 8]);
		end
		if (masked) begin
			for (int k = 0; k < 4; k++)
				push_byte(key[8*k +: 8]);
		end
		for (int unsigned i = 0; i < body; i++)
			push_byte(fill_ext ? (i[0] ? 8'hff : 8'h00) : 8'($urandom));
	endtask

	// Well-formed frame with random content; lengths mostly short, extended
	// forms also carrying values a shorter form would have covered.
	task automatic random_frame();
		int unsigned r;
		len_form_e form;
		logic [63:0] len;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			form = LEN_SHORT;
			len = '0;
		end else if (r < 70) begin
			form = LEN_SHORT;
			len = 64'($urandom_range(1, 20));
		end else if (r < 82) begin
			form = LEN_SHORT;
			len = 64'($urandom_range(21, 125));
		end else if (r < 94) begin
			form = LEN_EXT16;
			len = 64'($urandom_range(0, 300));
		end else begin
			form = LEN_EXT64;
			len = 64'($urandom_range(0, 600));
		end
		send_frame(4'($urandom_range(OPC_CONT, OPC_BIN)), 1'($urandom),
			$urandom_range(0, 9) < 7, form, len, int'(len), 1'b0, $urandom);
	endtask

	// Result side: random stall pattern, plus one long hold-off once traffic
	// is flowing, while the sender keeps offering bytes.
	initial begin
		int unsigned run_left;
		int unsigned gap_left;
		bit held;
		res_stall = 1'b0;
		run_left = 0;
		gap_left = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && bytes_out >= HOLD_AFTER) begin
				held = 1;
				gap_left = HOLD_CYCLES;
			end
			if (gap_left > 0) begin
				res_stall <= 1'b1;
				gap_left--;
			end else begin
				res_stall <= 1'b0;
				if (run_left > 0) begin
					run_left--;
				end else begin
					// sometimes a long stretch that never stalls
					run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100)
						: $urandom_range(0, 6);
					gap_left = idle_len();
				end
			end
		end
	end

	// Both channels are sampled at the rising edge: results are checked first,
	// then the byte taken at this edge goes into the predictor.
	always @(posedge clk) begin : sample
		wsd_pkg::res_t got;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got.payload_byte = payload_byte;
				got.frame_end = frame_end;
				got.frame_fin = frame_fin;
				got.frame_opcode = frame_opcode;
				got.proto_error = proto_error;
				bytes_out++;
				if (proto_error)
					err_out++;
				book.match_byte(got);
			end
			if (src_valid && !src_stall) begin
				bytes_in++;
				book.take_byte(in_byte);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, book.pending.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		logic [3:0] bad_opc;
		len_form_e bad_form;
		logic [63:0] bad_len;
		book = new();
		arst_n = 1'b0;
		src_valid = 1'b0;
		in_byte = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: one-byte text frame, masked binary with an all-ones key over
		// 00/ff data, empty continuation, empty 16-bit form, 64-bit form of one byte.
		send_frame(OPC_TEXT, 1'b1, 1'b0, LEN_SHORT, 64'd1, 1, 1'b1, 32'h0);
		send_frame(OPC_BIN, 1'b0, 1'b1, LEN_SHORT, 64'd3, 3, 1'b1, 32'hffff_ffff);
		send_frame(OPC_CONT, 1'b1, 1'b0, LEN_SHORT, 64'd0, 0, 1'b0, 32'h0);
		send_frame(OPC_TEXT, 1'b0, 1'b0, LEN_EXT16, 64'd0, 0, 1'b0, 32'h0);
		send_frame(OPC_CONT, 1'b0, 1'b0, LEN_EXT64, 64'd1, 1, 1'b1, 32'h0);

		// Random well-formed frames.
		while (bytes_in < ITEMS - TAIL_BYTES)
			random_frame();

		// 16-bit length with a nonzero high byte, masked.
		send_frame(OPC_BIN, 1'b1, 1'b1, LEN_EXT16, 64'd384, 384, 1'b0, $urandom);

		// Unsupported opcode last, since the error only clears on reset. Any length
		// form, 64-bit lengths fully random (top bit included); every byte after
		// the header must come back flagged.
		bad_opc = 4'($urandom_range(wsd_pkg::OPC_LAST_OK + 1, 15));
		bad_form = len_form_e'($urandom_range(LEN_SHORT, LEN_EXT64));
		case (bad_form)
			LEN_SHORT: bad_len = 64'($urandom_range(0, 125));
			LEN_EXT16: bad_len = 64'($urandom_range(0, 16'hffff));
			default:   bad_len = {$urandom, $urandom};
		endcase
		send_frame(bad_opc, 1'($urandom), 1'($urandom), bad_form, bad_len,
			$urandom_range(20, 40), 1'b0, $urandom);
		@(negedge clk);
		src_valid <= 1'b0;

		// drain, then give the two-stage pipe time to show any stray result
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (book.pending.size() != 0)
			book.report_mismatch($sformatf("%0d results never arrived",
				book.pending.size()));

		$display("%0d frames (%0d masked, %0d empty, %0d 16-bit, %0d 64-bit length)",
			n_frames, n_masked, n_empty, n_ext16, n_ext64);
		$display("%0d bytes in, %0d results out, %0d after opcode %0d, %0d mismatches",
			bytes_in, bytes_out, err_out, bad_opc, book.fails);
		if (book.fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
